@@ hw/rtl/fcp_pkg.sv @@
// types and constants shared by the framed command parser modules
package fcp_pkg;

    localparam logic [7:0]  START_MARKER_RESET = 8'h02;
    localparam logic [7:0]  END_MARKER_RESET   = 8'h03;
    localparam logic [15:0] MAX_LENGTH_RESET   = 16'd400;

    typedef enum logic [1:0] {
        CFG_START_MARKER = 2'd0,
        CFG_END_MARKER   = 2'd1,
        CFG_MAX_LENGTH   = 2'd2
    } cfg_index_t;

    typedef enum logic [7:0] {
        PH_START    = 8'b0000_0001,
        PH_SEQ      = 8'b0000_0010,
        PH_RESERVED = 8'b0000_0100,
        PH_COMMAND  = 8'b0000_1000,
        PH_LENGTH   = 8'b0001_0000,
        PH_PAYLOAD  = 8'b0010_0000,
        PH_CHECK    = 8'b0100_0000,
        PH_END      = 8'b1000_0000
    } phase_t;

    typedef enum logic [2:0] {
        ST_PROGRESS = 3'd0,
        ST_ACCEPTED = 3'd1,
        ST_DROPPED  = 3'd2,
        ST_LEN_REJ  = 3'd3,
        ST_BAD_END  = 3'd4,
        ST_HELD     = 3'd5,
        ST_RELEASED = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        FK_START    = 4'd0,
        FK_SEQ      = 4'd1,
        FK_RESERVED = 4'd2,
        FK_COMMAND  = 4'd3,
        FK_LENGTH   = 4'd4,
        FK_PAYLOAD  = 4'd5,
        FK_CHECK    = 4'd6,
        FK_END      = 4'd7,
        FK_NONE     = 4'd8
    } field_kind_t;

    typedef enum logic {
        REQ_BYTE    = 1'b0,
        REQ_RELEASE = 1'b1
    } req_type_t;

    typedef struct packed {
        req_type_t  req_type;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        status_t     status;
        field_kind_t field_kind;
        logic [15:0] field_index;
        logic [7:0]  byte_value;
        logic [7:0]  frame_seq;
        logic [7:0]  frame_command;
        logic [15:0] frame_length;
        logic [7:0]  frame_check;
    } result_t;

    typedef struct packed {
        logic [7:0]  start_marker;
        logic [7:0]  end_marker;
        logic [15:0] max_length;
    } cfg_t;

endpackage

@@ hw/rtl/framed_command_parser.sv @@
// top level of the framed command parser
// Parses a byte stream into start-marked, length-framed command packets and returns one result
// per request, tagging each byte with its field and position. Throughput is one request per
// clock while m_tready does not stall; a taken request passes the input register and then
// the result register, with the field classification in between, on its way to the m_ side.
// A stall on m_tready holds the result register and one more request in the input register;
// s_tready follows m_tready combinationally when both registers are full. Configuration writes
// take effect at once and do not reset the parser.
module framed_command_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    // field_index[15:0], byte_value[23:16], frame_seq[31:24], frame_command[39:32],
    // frame_length[55:40], frame_check[63:56]
    output logic [63:0] m_tdata,
    output logic [6:0]  m_tuser,   // status[2:0], field_kind[6:3]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    import fcp_pkg::*;

    logic    [7:0]  start_marker_reg;
    logic    [7:0]  end_marker_reg;
    logic    [15:0] max_length_reg;
    cfg_t           cfg;
    item_t          in_item;
    item_t          item;
    logic           item_valid;
    logic           load_ok;
    logic           fire;
    result_t        result;
    result_t        out_result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_marker_reg <= START_MARKER_RESET;
            end_marker_reg   <= END_MARKER_RESET;
            max_length_reg   <= MAX_LENGTH_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_START_MARKER: start_marker_reg <= cfg_wdata[7:0];
                CFG_END_MARKER:   end_marker_reg   <= cfg_wdata[7:0];
                CFG_MAX_LENGTH:   max_length_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg.start_marker = start_marker_reg;
    assign cfg.end_marker   = end_marker_reg;
    assign cfg.max_length   = max_length_reg;

    assign in_item.req_type = req_type_t'(s_tuser);
    assign in_item.rx_byte  = s_tdata;
    assign fire             = item_valid && load_ok;

    fcp_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .fire       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    fcp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item),
        .cfg     (cfg),
        .result  (result)
    );

    fcp_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .result     (result),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .load_ok    (load_ok),
        .out_result (out_result)
    );

    assign m_tdata = {out_result.frame_check, out_result.frame_length,
                      out_result.frame_command, out_result.frame_seq,
                      out_result.byte_value, out_result.field_index};
    assign m_tuser = {out_result.field_kind, out_result.status};

endmodule

@@ hw/rtl/fcp_in_reg.sv @@
// input register stage for received requests
module fcp_in_reg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  fcp_pkg::item_t in_item,
    input  logic          fire,
    output logic          item_valid,
    output fcp_pkg::item_t item
);
    import fcp_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    assign in_ready   = !valid_reg || fire;
    assign accept     = in_valid && in_ready;
    assign valid_next = accept ? 1'b1 : (fire ? 1'b0 : valid_reg);
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= in_item;
        end
    end

endmodule

@@ hw/rtl/fcp_core.sv @@
// frame parser state machine and per-byte classification
module fcp_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  fcp_pkg::item_t   item,
    input  fcp_pkg::cfg_t    cfg,
    output fcp_pkg::result_t result
);
    import fcp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [1:0]  sub_count_reg, sub_count_next;
    logic [7:0]  seq_number_reg, seq_number_next;
    logic [7:0]  command_code_reg, command_code_next;
    logic [15:0] payload_length_reg, payload_length_next;
    logic [15:0] payload_count_reg, payload_count_next;
    logic [7:0]  check_byte_reg, check_byte_next;
    logic        frame_held_reg, frame_held_next;
    logic        clear;
    logic [15:0] length_full;
    logic [15:0] count_inc;

    assign length_full = {payload_length_reg[15:8], item.rx_byte};
    assign count_inc   = payload_count_reg + 16'd1;

    always_comb begin
        phase_next          = phase_reg;
        sub_count_next      = sub_count_reg;
        seq_number_next     = seq_number_reg;
        command_code_next   = command_code_reg;
        payload_length_next = payload_length_reg;
        payload_count_next  = payload_count_reg;
        check_byte_next     = check_byte_reg;
        frame_held_next     = frame_held_reg;
        clear               = 1'b0;
        result              = '0;
        result.status       = ST_PROGRESS;
        result.field_kind   = FK_NONE;
        result.byte_value   = item.rx_byte;

        if (item.req_type == REQ_RELEASE) begin
            clear             = 1'b1;
            result.status     = ST_RELEASED;
            result.byte_value = 8'h00;
        end else if (frame_held_reg) begin
            result.status = ST_HELD;
        end else begin
            unique case (phase_reg)
                PH_START: begin
                    if (item.rx_byte == cfg.start_marker) begin
                        result.field_kind = FK_START;
                        phase_next        = PH_SEQ;
                    end else begin
                        result.status = ST_DROPPED;
                        clear         = 1'b1;
                    end
                end
                PH_SEQ: begin
                    result.field_kind = FK_SEQ;
                    seq_number_next   = item.rx_byte;
                    phase_next        = PH_RESERVED;
                    sub_count_next    = 2'd0;
                end
                PH_RESERVED: begin
                    result.field_kind  = FK_RESERVED;
                    result.field_index = {14'd0, sub_count_reg};
                    sub_count_next     = sub_count_reg + 2'd1;
                    if (sub_count_reg == 2'd3) begin
                        phase_next = PH_COMMAND;
                    end
                end
                PH_COMMAND: begin
                    result.field_kind = FK_COMMAND;
                    command_code_next = item.rx_byte;
                    phase_next        = PH_LENGTH;
                    sub_count_next    = 2'd0;
                end
                PH_LENGTH: begin
                    result.field_kind = FK_LENGTH;
                    if (!sub_count_reg[0]) begin
                        payload_length_next = {item.rx_byte, 8'h00};
                        sub_count_next      = 2'd1;
                    end else begin
                        result.field_index = 16'd1;
                        sub_count_next     = 2'd0;
                        if (length_full > cfg.max_length) begin
                            result.status = ST_LEN_REJ;
                            clear         = 1'b1;
                        end else begin
                            payload_length_next = length_full;
                            payload_count_next  = 16'd0;
                            phase_next = (length_full == 16'd0) ? PH_CHECK : PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    result.field_kind  = FK_PAYLOAD;
                    result.field_index = payload_count_reg;
                    payload_count_next = count_inc;
                    if (count_inc >= payload_length_reg) begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    result.field_kind = FK_CHECK;
                    check_byte_next   = item.rx_byte;
                    phase_next        = PH_END;
                end
                PH_END: begin
                    result.field_kind = FK_END;
                    if (item.rx_byte == cfg.end_marker) begin
                        result.status        = ST_ACCEPTED;
                        frame_held_next      = 1'b1;
                        result.frame_seq     = seq_number_reg;
                        result.frame_command = command_code_reg;
                        result.frame_length  = payload_length_reg;
                        result.frame_check   = check_byte_reg;
                    end else begin
                        result.status = ST_BAD_END;
                        clear         = 1'b1;
                    end
                end
                default: begin
                    clear = 1'b1;
                end
            endcase
        end

        if (clear) begin
            phase_next          = PH_START;
            sub_count_next      = 2'd0;
            seq_number_next     = 8'h00;
            command_code_next   = 8'h00;
            payload_length_next = 16'd0;
            payload_count_next  = 16'd0;
            check_byte_next     = 8'h00;
            frame_held_next     = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_START;
            sub_count_reg      <= 2'd0;
            seq_number_reg     <= 8'h00;
            command_code_reg   <= 8'h00;
            payload_length_reg <= 16'd0;
            payload_count_reg  <= 16'd0;
            check_byte_reg     <= 8'h00;
            frame_held_reg     <= 1'b0;
        end else if (fire) begin
            phase_reg          <= phase_next;
            sub_count_reg      <= sub_count_next;
            seq_number_reg     <= seq_number_next;
            command_code_reg   <= command_code_next;
            payload_length_reg <= payload_length_next;
            payload_count_reg  <= payload_count_next;
            check_byte_reg     <= check_byte_next;
            frame_held_reg     <= frame_held_next;
        end
    end

    // a held frame always sits at the end marker
    a_held_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_held_reg |-> phase_reg == PH_END)
        else $error("frame held outside end phase");

    // payload counter never reaches the declared length while in payload
    a_payload_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> payload_count_reg < payload_length_reg)
        else $error("payload count overran length");

    // release request always returns the parser to the start phase
    a_release_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.req_type == REQ_RELEASE |=> phase_reg == PH_START && !frame_held_reg)
        else $error("release did not clear parser");

    // bytes arriving while held leave the parser untouched
    a_held_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && frame_held_reg && item.req_type == REQ_BYTE
        |=> frame_held_reg && $stable(payload_length_reg) && $stable(seq_number_reg))
        else $error("held frame disturbed by received byte");

endmodule

@@ hw/rtl/fcp_out_reg.sv @@
// result register stage toward the output stream
module fcp_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  fcp_pkg::result_t result,
    input  logic             out_ready,
    output logic             out_valid,
    output logic             load_ok,
    output fcp_pkg::result_t out_result
);
    import fcp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign load_ok    = !valid_reg || out_ready;
    assign valid_next = fire ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            result_reg <= result;
        end
    end

endmodule
